FILE: rtl/csd_pkg.sv
// Shared types, sizes and helpers of the census stereo matcher.
package csd_pkg;

   localparam int WINDOW    = 7;
   localparam int CENTER    = (WINDOW - 1) / 2;
   localparam int LINES     = WINDOW - 1;
   localparam int CODE_W    = WINDOW * WINDOW - 1;
   localparam int COL_DEPTH = 1024;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 12;
   localparam int MAX_DISP  = 64;
   localparam int HIST_AW   = $clog2(MAX_DISP);
   localparam int DISP_W    = 9;
   localparam int COST_W    = 9;
   localparam int NUM_LANES = 4;
   localparam logic [COST_W-1:0] COST_NONE = '1;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_NUM_DISP     = 2'd2,
      CSR_MAX_COST     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] left_pixel;
      logic [7:0] right_pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [5:0]       disparity;
      logic [7:0]       best_cost;
      logic [ROW_W-1:0] out_row;
      logic [COL_W-1:0] out_col;
      logic             frame_end;
   } rsp_type;

   typedef struct packed {
      logic              init;
      logic              step;
      logic [DISP_W-1:0] base;
   } merge_ctrl_type;

   function automatic logic [COST_W-1:0] popcount(input logic [CODE_W-1:0] v);
      logic [COST_W-1:0] n;
      n = '0;
      for (int i = 0; i < CODE_W; i++) begin
         n = n + COST_W'(v[i]);
      end
      return n;
   endfunction

endpackage

FILE: rtl/csd_census.sv
// Window registers of one image and its census code.
module csd_census (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [csd_pkg::WINDOW*8-1:0] column_in,
   output logic [csd_pkg::CODE_W-1:0]  code
);
   import csd_pkg::*;

   logic [7:0] win_ff [WINDOW][WINDOW];

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
            win_ff[i][WINDOW-1] <= column_in[i*8 +: 8];
         end
      end
   end

   // row-major, center skipped; set when center < neighbor
   always_comb begin
      int pos;
      pos  = 0;
      code = '0;
      for (int i = 0; i < WINDOW; i++) begin
         for (int j = 0; j < WINDOW; j++) begin
            if (!(i == CENTER && j == CENTER)) begin
               code[pos] = (win_ff[CENTER][CENTER] < win_ff[i][j]);
               pos = pos + 1;
            end
         end
      end
   end

endmodule

FILE: rtl/csd_lane.sv
// One disparity lane: private copy of the right code history and a cost unit.
module csd_lane (
   input  logic                         clock,
   input  logic                         hist_we,
   input  logic [csd_pkg::HIST_AW-1:0]  hist_waddr,
   input  logic [csd_pkg::CODE_W-1:0]   hist_wdata,
   input  logic [csd_pkg::HIST_AW-1:0]  rd_addr,
   input  logic                         rd_active,
   input  logic                         rd_use_max,
   input  logic [csd_pkg::CODE_W-1:0]   left_code,
   input  logic [7:0]                   max_cost,
   output logic [csd_pkg::COST_W-1:0]   cost
);
   import csd_pkg::*;

   logic [CODE_W-1:0] hist_mem [MAX_DISP];
   logic [CODE_W-1:0] rd_data_ff;
   logic              active_ff;
   logic              use_max_ff;
   logic [COST_W-1:0] cost_ff;
   logic [COST_W-1:0] cost_in;

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      rd_data_ff <= hist_mem[rd_addr];
      active_ff  <= rd_active;
      use_max_ff <= rd_use_max;
      cost_ff    <= cost_in;
   end

   always_comb begin
      if (!active_ff) begin
         cost_in = COST_NONE;
      end else if (use_max_ff) begin
         cost_in = {1'b0, max_cost};
      end else begin
         cost_in = popcount(left_code ^ rd_data_ff);
      end
   end

   assign cost = cost_ff;

endmodule

FILE: rtl/csd_merge.sv
// Merging stage: running first-minimum over the lane costs.
module csd_merge #(
   parameter int LANES = csd_pkg::NUM_LANES
) (
   input  logic                         clock,
   input  csd_pkg::merge_ctrl_type      ctrl,
   input  logic [csd_pkg::COST_W-1:0]   lane_cost [LANES],
   output logic [csd_pkg::COST_W-1:0]   best_cost,
   output logic [csd_pkg::DISP_W-1:0]   best_disp
);
   import csd_pkg::*;

   logic [COST_W-1:0] best_ff, best_in;
   logic [DISP_W-1:0] disp_ff, disp_in;

   always_comb begin
      best_in = ctrl.init ? COST_NONE : best_ff;
      disp_in = ctrl.init ? '0 : disp_ff;
      for (int k = 0; k < LANES; k++) begin
         if (lane_cost[k] < best_in) begin
            best_in = lane_cost[k];
            disp_in = ctrl.base + DISP_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         best_ff <= best_in;
         disp_ff <= disp_in;
      end
   end

   assign best_cost = best_ff;
   assign best_disp = disp_ff;

endmodule

FILE: rtl/census_stereo_disparity.sv
// Top level of the census-transform stereo matcher.
//
//  port group | dir | handshake         | moves
//  req_       | in  | valid / stall     | one left/right pixel pair per transfer
//  rsp_       | out | valid / stall     | one disparity result per full window
//  csr_       | in  | valid / ready     | register index + write data
//
// Flow: one pixel pair at a time. A pixel with no full window passes LOAD and
// returns to IDLE; one with a result goes LOAD, CENSUS, then READ, COST, MERGE
// per group of NUM_LANES up to the clamped disparity count, and last EMIT.
// Reset: synchronous; afterwards a clearing pass over every address zeroes the line
// memory, during which req_stall stays high (csr writes still taken).
// Stalls: a result waits in the output register; the block holds in its emit
// step only when the next result is ready while the previous one is still held.
module census_stereo_disparity #(
   parameter int NUM_LANES = csd_pkg::NUM_LANES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output csd_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data
);
   import csd_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_LOAD, S_CENSUS, S_READ, S_COST, S_MERGE, S_EMIT
   } state_type;

   localparam int WORD_W = 2 * LINES * 8;

   state_type state_ff;

   // config registers
   logic [10:0] width_ff;
   logic [11:0] height_ff;
   logic [6:0]  ndisp_ff;
   logic [7:0]  max_cost_ff;

   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0] clr_addr_ff;

   // per-pixel registers
   logic [7:0]       lpix_ff, rpix_ff;
   logic [COL_W-1:0] col_ff, oc_ff;
   logic [ROW_W-1:0] orow_ff;
   logic             has_out_ff, fend_ff;
   logic [DISP_W-1:0] base_ff;
   logic [CODE_W-1:0] lcode_ff;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             emit_go;

   // line memory: per column the LINES previous rows, left then right
   logic [WORD_W-1:0] line_mem [COL_DEPTH];
   logic [WORD_W-1:0] line_rd_ff;
   logic              line_we;
   logic [COL_W-1:0]  line_waddr;
   logic [WORD_W-1:0] line_wdata;

   logic accept;
   logic [10:0] w_eff;
   logic [11:0] h_eff;
   logic [6:0]  nd_eff;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic [10:0] col_inc;
   logic [12:0] row_inc;

   logic [WINDOW*8-1:0] lcol, rcol;
   logic [CODE_W-1:0]   lcode, rcode;
   logic                shift_en;

   logic [HIST_AW-1:0] lane_addr    [NUM_LANES];
   logic               lane_active  [NUM_LANES];
   logic               lane_use_max [NUM_LANES];
   logic [COST_W-1:0]  lane_cost    [NUM_LANES];
   merge_ctrl_type     mctrl;
   logic [COST_W-1:0]  best_cost;
   logic [DISP_W-1:0]  best_disp;
   logic               last_group;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // result register free, or emptied at this edge
   assign emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // clamped sizes
   always_comb begin
      w_eff  = (width_ff == '0) ? 11'd1 : (width_ff > 11'd1024) ? 11'd1024 : width_ff;
      h_eff  = (height_ff == '0) ? 12'd1 : height_ff;
      nd_eff = (ndisp_ff == '0) ? 7'd1 :
               (ndisp_ff > 7'(MAX_DISP)) ? 7'(MAX_DISP) : ndisp_ff;
   end

   // position of the incoming pixel and counter advance
   always_comb begin
      col_cur = req_payload.frame_start ? '0 : col_cnt_ff;
      row_cur = req_payload.frame_start ? '0 : row_cnt_ff;
      if ({1'b0, col_cur} >= w_eff) col_cur = '0;
      if (row_cur >= h_eff) row_cur = '0;
      col_inc    = {1'b0, col_cur} + 11'd1;
      row_inc    = {1'b0, row_cur};
      col_cnt_in = col_inc[COL_W-1:0];
      row_cnt_in = row_cur;
      if (col_inc >= w_eff) begin
         col_cnt_in = '0;
         row_inc    = {1'b0, row_cur} + 13'd1;
         row_cnt_in = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
      end
   end

   // window columns from the line word plus the new pixel
   always_comb begin
      for (int i = 0; i < LINES; i++) begin
         lcol[i*8 +: 8] = line_rd_ff[i*8 +: 8];
         rcol[i*8 +: 8] = line_rd_ff[LINES*8 + i*8 +: 8];
      end
      lcol[LINES*8 +: 8] = lpix_ff;
      rcol[LINES*8 +: 8] = rpix_ff;
   end

   assign shift_en = (state_ff == S_LOAD);

   always_comb begin
      line_we    = 1'b0;
      line_waddr = col_ff;
      line_wdata = '0;
      if (state_ff == S_CLEAR) begin
         line_we    = 1'b1;
         line_waddr = clr_addr_ff;
      end else if (state_ff == S_LOAD) begin
         line_we = 1'b1;
         for (int i = 0; i < LINES - 1; i++) begin
            line_wdata[i*8 +: 8]               = line_rd_ff[(i+1)*8 +: 8];
            line_wdata[LINES*8 + i*8 +: 8]     = line_rd_ff[LINES*8 + (i+1)*8 +: 8];
         end
         line_wdata[(LINES-1)*8 +: 8]          = lpix_ff;
         line_wdata[LINES*8 + (LINES-1)*8 +: 8] = rpix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) line_mem[line_waddr] <= line_wdata;
      if (accept)  line_rd_ff <= line_mem[col_cur];
   end

   csd_census u_left (
      .clock(clock), .shift_en(shift_en), .column_in(lcol), .code(lcode)
   );
   csd_census u_right (
      .clock(clock), .shift_en(shift_en), .column_in(rcol), .code(rcode)
   );

   // lane d = base + k reads the right code d columns back
   always_comb begin
      logic [DISP_W-1:0] d;
      logic [COL_W:0]    diff;
      for (int k = 0; k < NUM_LANES; k++) begin
         d               = base_ff + DISP_W'(k);
         diff            = {1'b0, oc_ff} - (COL_W+1)'(d);
         lane_addr[k]    = diff[HIST_AW-1:0];
         lane_active[k]  = (d < DISP_W'(nd_eff));
         lane_use_max[k] = ((COL_W+1)'(oc_ff) < (COL_W+1)'(d));
      end
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
      csd_lane u_lane (
         .clock      (clock),
         .hist_we    (state_ff == S_CENSUS),
         .hist_waddr (oc_ff[HIST_AW-1:0]),
         .hist_wdata (rcode),
         .rd_addr    (lane_addr[k]),
         .rd_active  (lane_active[k]),
         .rd_use_max (lane_use_max[k]),
         .left_code  (lcode_ff),
         .max_cost   (max_cost_ff),
         .cost       (lane_cost[k])
      );
   end

   always_comb begin
      mctrl.init = (base_ff == '0);
      mctrl.step = (state_ff == S_MERGE);
      mctrl.base = base_ff;
   end

   csd_merge #(.LANES(NUM_LANES)) u_merge (
      .clock(clock), .ctrl(mctrl), .lane_cost(lane_cost),
      .best_cost(best_cost), .best_disp(best_disp)
   );

   assign last_group = (base_ff + DISP_W'(NUM_LANES)) >= DISP_W'(nd_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         col_cnt_ff   <= '0;
         row_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= 11'd640;
         height_ff    <= 12'd480;
         ndisp_ff     <= 7'd64;
         max_cost_ff  <= 8'd255;
         base_ff      <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  width_ff    <= csr_data[10:0];
               CSR_IMAGE_HEIGHT: height_ff   <= csr_data[11:0];
               CSR_NUM_DISP:     ndisp_ff    <= csr_data[6:0];
               CSR_MAX_COST:     max_cost_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         if (emit_go) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == COL_W'(COL_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (accept) begin
                  lpix_ff    <= req_payload.left_pixel;
                  rpix_ff    <= req_payload.right_pixel;
                  col_ff     <= col_cur;
                  oc_ff      <= col_cur - COL_W'(LINES);
                  orow_ff    <= row_cur - ROW_W'(LINES);
                  has_out_ff <= (row_cur >= ROW_W'(LINES)) && (col_cur >= COL_W'(LINES));
                  fend_ff    <= (row_cur == h_eff - 12'd1) &&
                                ({1'b0, col_cur} == w_eff - 11'd1);
                  col_cnt_ff <= col_cnt_in;
                  row_cnt_ff <= row_cnt_in;
                  state_ff   <= S_LOAD;
               end
            end
            S_LOAD:   state_ff <= has_out_ff ? S_CENSUS : S_IDLE;
            S_CENSUS: begin
               lcode_ff <= lcode;
               base_ff  <= '0;
               state_ff <= S_READ;
            end
            S_READ:   state_ff <= S_COST;
            S_COST:   state_ff <= S_MERGE;
            S_MERGE: begin
               base_ff  <= base_ff + DISP_W'(NUM_LANES);
               state_ff <= last_group ? S_EMIT : S_READ;
            end
            S_EMIT: begin
               if (emit_go) begin
                  rsp_data_ff.disparity <= best_disp[5:0];
                  rsp_data_ff.best_cost <= best_cost[7:0];
                  rsp_data_ff.out_row   <= orow_ff;
                  rsp_data_ff.out_col   <= oc_ff;
                  rsp_data_ff.frame_end <= fend_ff;
                  base_ff               <= '0;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/csd_checker.sv
// Port-level checker of the stereo matcher and its bind.
module csd_port_props (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input csd_pkg::rsp_type rsp_payload
);
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall) else $error("input open right after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transfer taken while an item is at work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   a_result_needs_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no item at work");
endmodule

bind census_stereo_disparity csd_port_props u_csd_port_props (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
);

FILE: bench/csd_checker.sv
// Channel monitor, disparity predictor and result comparison for the census stereo matcher.
`timescale 1ns / 1ps

module csd_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  csd_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  csd_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_data,
   output int               errors,
   output int               pending
);
   import csd_pkg::*;

   localparam int SIDE = 7;
   localparam int MID  = (SIDE - 1) / 2;

   logic [7:0]  line_mem [2][SIDE-1][1024];   // [0] left image, [1] right image
   logic [7:0]  win_mem  [2][SIDE][SIDE];
   logic [47:0] right_codes [64];
   int unsigned col_cnt, row_cnt;
   logic [10:0] width_reg;
   logic [11:0] height_reg;
   logic [6:0]  ndisp_reg;
   logic [7:0]  maxcost_reg;
   rsp_type     expected_results [$];

   assign pending = expected_results.size();

   function automatic void shift_column(int s, int unsigned col, logic [7:0] pix);
      for (int i = 0; i < SIDE; i++)
         for (int j = 0; j < SIDE - 1; j++)
            win_mem[s][i][j] = win_mem[s][i][j+1];
      for (int i = 0; i < SIDE - 1; i++)
         win_mem[s][i][SIDE-1] = line_mem[s][i][col];
      win_mem[s][SIDE-1][SIDE-1] = pix;
      for (int i = 0; i < SIDE - 2; i++)
         line_mem[s][i][col] = line_mem[s][i+1][col];
      line_mem[s][SIDE-2][col] = pix;
   endfunction

   function automatic logic [47:0] census_of(int s);
      logic [47:0] code;
      int          bitpos;
      code   = '0;
      bitpos = 0;
      for (int i = 0; i < SIDE; i++)
         for (int j = 0; j < SIDE; j++) begin
            if (!(i == MID && j == MID)) begin
               if (win_mem[s][MID][MID] < win_mem[s][i][j])
                  code[bitpos] = 1'b1;
               bitpos++;
            end
         end
      return code;
   endfunction

   function automatic void predict_disparity(req_type p);
      int unsigned w, h, nd, col, row, oc, best, bestd, cost;
      logic [47:0] lc, rc;
      rsp_type     r;
      w  = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
      h  = (height_reg == 0) ? 1 : height_reg;
      nd = (ndisp_reg == 0) ? 1 : (ndisp_reg > 64) ? 64 : ndisp_reg;
      if (p.frame_start) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      // a size shrunk under a running frame restarts the counter
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      col = col_cnt;
      row = row_cnt;
      shift_column(0, col % 1024, p.left_pixel);
      shift_column(1, col % 1024, p.right_pixel);
      if (row >= SIDE - 1 && col >= SIDE - 1) begin
         oc  = col - (SIDE - 1);
         lc  = census_of(0);
         rc  = census_of(1);
         right_codes[oc % 64] = rc;
         best  = $countones(lc ^ rc);
         bestd = 0;
         for (int unsigned d = 1; d < nd; d++) begin
            cost = (oc >= d) ? $countones(lc ^ right_codes[(oc - d) % 64]) : maxcost_reg;
            if (cost < best) begin
               best  = cost;
               bestd = d;
            end
         end
         r.disparity = bestd[5:0];
         r.best_cost = best[7:0];
         r.out_row   = 12'(row - (SIDE - 1));
         r.out_col   = 10'(oc);
         r.frame_end = (row == h - 1 && col == w - 1);
         expected_results.push_back(r);
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      col_cnt = col & 32'h3FF;
      row_cnt = row & 32'hFFF;
   endfunction

   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         foreach (line_mem[s, i, c]) line_mem[s][i][c] = '0;
         foreach (win_mem[s, i, j]) win_mem[s][i][j] = '0;
         col_cnt     = 0;
         row_cnt     = 0;
         width_reg   = 11'd640;
         height_reg  = 12'd480;
         ndisp_reg   = 7'd64;
         maxcost_reg = 8'd255;
         errors      = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, got %p", $time, rsp_payload);
               errors++;
            end else begin
               e = expected_results.pop_front();
               check_field("disparity", e.disparity, rsp_payload.disparity);
               check_field("best_cost", e.best_cost, rsp_payload.best_cost);
               check_field("out_row",   e.out_row,   rsp_payload.out_row);
               check_field("out_col",   e.out_col,   rsp_payload.out_col);
               check_field("frame_end", e.frame_end, rsp_payload.frame_end);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  width_reg   = csr_data[10:0];
               CSR_IMAGE_HEIGHT: height_reg  = csr_data[11:0];
               CSR_NUM_DISP:     ndisp_reg   = csr_data[6:0];
               CSR_MAX_COST:     maxcost_reg = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_disparity(req_payload);
      end
   end

endmodule

FILE: bench/testbench.sv
// Stimulus, stall patterns and verdict for the census stereo matcher.
`timescale 1ns / 1ps

module testbench;
   import csd_pkg::*;

   localparam int IDLE_LIMIT = 6000;   // covers the clearing pass and the long receiver hold
   localparam int NPHASES    = 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   int          errors;
   int          pending;
   int          results_seen = 0;
   int          idle_cycles = 0;
   bit          quiet_sender;

   // Phase settings: width, height, disparities, max cost, item count, open with
   // frame_start. Out-of-range sizes and counts exercise the clamps; the phases that
   // open without frame_start carry counters on; phase 6 meets those of a wider frame.
   int ph_w  [NPHASES] = '{16,  9, 24,  0,   20, 2047, 13,   8};
   int ph_h  [NPHASES] = '{ 8,  7, 12,  0, 4095, 4095,  9,   8};
   int ph_nd [NPHASES] = '{64,  1,  0,  5,  127,   64, 64,  64};
   int ph_mc [NPHASES] = '{255, 0, 17, 100, 255,    3,  0, 255};
   int ph_n  [NPHASES] = '{256, 128, 220, 30, 200,  60, 100, 100};
   bit ph_fs [NPHASES] = '{0,   1,   1,   1,   1,    1,   0,   1};

   always #5 clock = ~clock;

   census_stereo_disparity u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   csd_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .errors, .pending
   );

   // all four registers in one burst; valid stays up between transfers
   task automatic write_settings(int w, int h, int nd, int mc);
      int vals [4];
      vals = '{w, h, nd, mc};
      for (int i = 0; i < 4; i++) begin
         csr_index <= 2'(i);
         csr_data  <= 16'(vals[i]);
         csr_valid <= 1'b1;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // one pixel-pair transfer, preceded by an idle gap when gap is nonzero
   task automatic send_pixel(req_type p, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= p;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic int sender_gap();
      int r;
      if (quiet_sender) return 0;
      r = $urandom_range(0, 19);
      if (r < 10) return 0;
      if (r < 19) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   // mix of textures: noise, saturated extremes, flat regions (census ties), equal views
   function automatic req_type random_pixel();
      req_type p;
      p.left_pixel  = 8'($urandom);
      p.right_pixel = 8'($urandom);
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            p.left_pixel  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.right_pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         2: begin
            p.left_pixel  = 8'(100 + $urandom_range(0, 2));
            p.right_pixel = 8'(100 + $urandom_range(0, 2));
         end
         default: p.right_pixel = p.left_pixel;
      endcase
      p.frame_start = ($urandom_range(0, 299) == 0);   // stray frame restarts
      return p;
   endfunction

   // wait out every expected result plus the block's own latency
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // receiver: bursts of stalls, mostly short, one long hold once results flow
   initial begin
      bit held_long;
      int r;
      held_long = 0;
      rsp_stall <= 1'b0;
      forever begin
         if (!held_long && results_seen >= 30) begin
            held_long = 1;
            rsp_stall <= 1'b1;
            repeat (700) @(posedge clock);
         end
         r = $urandom_range(0, 9);
         if (r < 4) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else if (r < 9) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) results_seen <= results_seen + 1;
   end

   // watchdog: cycles without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      req_type p;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= CSR_IMAGE_WIDTH;
      csr_data     <= '0;
      quiet_sender = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: saturated and flat pixels opening a 16 x 8 frame
      write_settings(ph_w[0], ph_h[0], ph_nd[0], ph_mc[0]);
      for (int i = 0; i < 25; i++) begin
         p.frame_start = (i == 0);
         case (i % 5)
            0: begin p.left_pixel = 8'h00; p.right_pixel = 8'hFF; end
            1: begin p.left_pixel = 8'hFF; p.right_pixel = 8'h00; end
            2: begin p.left_pixel = 8'hFF; p.right_pixel = 8'hFF; end
            3: begin p.left_pixel = 8'h00; p.right_pixel = 8'h00; end
            default: begin p.left_pixel = 8'h80; p.right_pixel = 8'h7F; end
         endcase
         send_pixel(p, 0);
      end

      for (int ph = 0; ph < NPHASES; ph++) begin
         if (ph != 0) write_settings(ph_w[ph], ph_h[ph], ph_nd[ph], ph_mc[ph]);
         quiet_sender = (ph % 3 == 2);
         for (int i = 0; i < ph_n[ph]; i++) begin
            p = random_pixel();
            if (i == 0 && ph_fs[ph]) p.frame_start = 1'b1;
            send_pixel(p, sender_gap());
         end
         drain();
      end

      if (errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
